/* src/gdcc_pkg.sv */
// ----------------------------------------------------------------------------
// gdcc_pkg: shared types and constants of the debounced click counter
// Pin count, field widths, register indexes, op and query codes, lane types.
// ----------------------------------------------------------------------------
package gdcc_pkg;

  // Number of pins that have counters (1 to 16 reachable by mask and index).
  localparam int PIN_COUNT = 16;
  // Width of a pin number inside the block.
  localparam int PIN_IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

  // Port field widths.
  localparam int MASK_W    = 16;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 32;
  localparam int IDX_W     = 4;
  localparam int MODE_W    = 2;
  localparam int VALUE_W   = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;
  localparam int REG_W     = 16;

  localparam logic [REG_W-1:0] DEBOUNCE_RST = REG_W'(200);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_ENABLE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = CFG_IDX_W'(1);

  // Answer for a pin that has no counters.
  localparam logic [VALUE_W-1:0] VALUE_NO_PIN = '1;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    QM_TOTAL  = 2'd0,
    QM_STATUS = 2'd1,
    QM_DELTA  = 2'd2,
    QM_LAST   = 2'd3
  } query_mode_e;

  // Per-pin counter state.
  typedef struct packed {
    logic [TIME_W-1:0] last_time;
    logic [CNT_W-1:0]  since_clear;
    logic [CNT_W-1:0]  total;
  } lane_state_t;

  // Per-pin update strobes.
  typedef struct packed {
    logic click_check; // event retires and pin is pending and enabled
    logic clear;       // query clears the clicks-since-clear count
  } lane_cmd_t;

endpackage

/* src/gdcc_pin_lane.sv */
// ----------------------------------------------------------------------------
// gdcc_pin_lane: counters of one pin
// Debounce compare, last click time, clicks-since-clear and total counts.
// ----------------------------------------------------------------------------
module gdcc_pin_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gdcc_pkg::lane_cmd_t         cmd_i,
  input  logic [gdcc_pkg::TIME_W-1:0] now_ms_i,
  input  logic [gdcc_pkg::TIME_W-1:0] limit_i,
  output gdcc_pkg::lane_state_t       state_o
);
  import gdcc_pkg::*;

  lane_state_t state_d, state_q;
  logic        hit;

  // Unsigned compare against the wrapped window start.
  assign hit = cmd_i.click_check && (state_q.last_time < limit_i);

  always_comb begin
    state_d = state_q;
    if (hit) begin
      state_d.last_time   = now_ms_i;
      state_d.since_clear = state_q.since_clear + CNT_W'(1);
      state_d.total       = state_q.total + CNT_W'(1);
    end
    if (cmd_i.clear) begin
      state_d.since_clear = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

/* src/gdcc_query.sv */
// ----------------------------------------------------------------------------
// gdcc_query: query answer select
// Picks one pin's counters and forms the answer for the query mode.
// ----------------------------------------------------------------------------
module gdcc_query (
  input  gdcc_pkg::lane_state_t [gdcc_pkg::PIN_COUNT-1:0] lanes_i,
  input  logic [gdcc_pkg::IDX_W-1:0]                      pin_index_i,
  input  gdcc_pkg::query_mode_e                           mode_i,
  output logic [gdcc_pkg::VALUE_W-1:0]                    value_o,
  output logic [gdcc_pkg::PIN_COUNT-1:0]                  clear_o
);
  import gdcc_pkg::*;

  logic                 in_range;
  logic [PIN_IDX_W-1:0] sel;
  lane_state_t          lane;
  logic [VALUE_W-1:0]   answer;
  logic                 clears;

  assign in_range = (32'(pin_index_i) < PIN_COUNT);
  assign sel      = PIN_IDX_W'(pin_index_i);
  assign lane     = lanes_i[sel];

  always_comb begin
    answer = lane.total;
    clears = 1'b0;
    case (mode_i)
      QM_TOTAL: begin
        answer = lane.total;
      end
      QM_STATUS: begin
        // negative total when nothing was clicked since the last clear
        answer = (lane.since_clear == '0) ? (VALUE_W'(0) - lane.total) : lane.total;
        clears = 1'b1;
      end
      QM_DELTA: begin
        answer = lane.since_clear;
        clears = 1'b1;
      end
      QM_LAST: begin
        answer = lane.last_time;
      end
      default: begin
        answer = lane.total;
      end
    endcase
  end

  always_comb begin
    clear_o = '0;
    if (in_range && clears) begin
      clear_o[sel] = 1'b1;
    end
  end

  assign value_o = in_range ? answer : VALUE_NO_PIN;

endmodule

/* src/gpio_debounced_click_counter_unit.sv */
// ----------------------------------------------------------------------------
// gpio_debounced_click_counter_unit: debounced per-pin click counter
// Counts debounced GPIO clicks per pin and answers counter queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one beat per item: an
//   event (op 0: pin_mask_i, now_ms_i) or a query (op 1: pin_index_i,
//   query_mode_i). Events produce no output beat; each query produces one
//   beat on value_o (out_valid_o / out_stall_i).
//   A query passes through the input register, then the result register,
//   before it shows on out_valid_o. Throughput: one item per cycle while no
//   query waits behind a stalled result, set by the single pass from the input
//   register through the pin lanes and answer select into the result register.
//   An event updates the counters when it leaves the input register, so the
//   next item always sees its effect.
//   When the receiver stalls, the result register holds; a query waiting
//   behind it then holds the input register and in_stall_o rises. Events
//   keep draining while a result waits.
//   Configuration: cfg_valid_i / cfg_ready_o, ready always high; index 0
//   pin_enable, index 1 debounce_ms, others ignored. Write only when idle.
//   Reset: all counters and times zero, pin_enable 0, debounce_ms 200,
//   no beat pending.
// ----------------------------------------------------------------------------
module gpio_debounced_click_counter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gdcc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gdcc_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [gdcc_pkg::MASK_W-1:0]      pin_mask_i,
  input  logic [gdcc_pkg::TIME_W-1:0]      now_ms_i,
  input  logic [gdcc_pkg::IDX_W-1:0]       pin_index_i,
  input  logic [gdcc_pkg::MODE_W-1:0]      query_mode_i,
  // results
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [gdcc_pkg::VALUE_W-1:0] value_o
);
  import gdcc_pkg::*;

  // configuration registers
  logic [REG_W-1:0] pin_enable_q;
  logic [REG_W-1:0] debounce_q;

  // input register
  logic               s1_valid_q;
  op_e                s1_op_q;
  logic [MASK_W-1:0]  s1_live_q;
  logic [TIME_W-1:0]  s1_now_q;
  logic [TIME_W-1:0]  s1_limit_q;
  logic [IDX_W-1:0]   s1_idx_q;
  query_mode_e        s1_mode_q;

  // result register
  logic               out_valid_q;
  logic [VALUE_W-1:0] out_value_q;

  logic in_accept;
  logic out_free;
  logic s1_adv;
  logic ev_go;
  logic qy_go;

  lane_state_t [PIN_COUNT-1:0] lanes;
  logic [PIN_COUNT-1:0]        q_clear;
  logic [VALUE_W-1:0]          q_value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_enable_q <= '0;
      debounce_q   <= DEBOUNCE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_PIN_ENABLE) begin
        pin_enable_q <= cfg_data_i[REG_W-1:0];
      end else if (cfg_index_i == CFG_DEBOUNCE_MS) begin
        debounce_q <= cfg_data_i[REG_W-1:0];
      end
    end
  end

  // Handshake: events always retire; a query needs room in the result reg.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && ((s1_op_q == OP_EVENT) || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ev_go      = s1_adv && (s1_op_q == OP_EVENT);
  assign qy_go      = s1_adv && (s1_op_q == OP_QUERY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Mask, window start settled on entry; user keeps config static (unchecked).
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q    <= op_e'(op_i);
      s1_live_q  <= pin_mask_i & pin_enable_q;
      s1_now_q   <= now_ms_i;
      s1_limit_q <= now_ms_i - TIME_W'(debounce_q);
      s1_idx_q   <= pin_index_i;
      s1_mode_q  <= query_mode_e'(query_mode_i);
    end
  end

  // pin lanes
  for (genvar p = 0; p < PIN_COUNT; p++) begin : g_lane
    lane_cmd_t cmd;
    if (p < MASK_W) begin : g_masked
      assign cmd.click_check = ev_go && s1_live_q[p];
    end else begin : g_nomask
      assign cmd.click_check = 1'b0;
    end
    assign cmd.clear = qy_go && q_clear[p];

    gdcc_pin_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .now_ms_i (s1_now_q),
      .limit_i  (s1_limit_q),
      .state_o  (lanes[p])
    );
  end

  gdcc_query u_query (
    .lanes_i     (lanes),
    .pin_index_i (s1_idx_q),
    .mode_i      (s1_mode_q),
    .value_o     (q_value),
    .clear_o     (q_clear)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= qy_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (qy_go) begin
      out_value_q <= q_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = signed'(out_value_q);

`ifndef SYNTHESIS
  // Input backs up only behind a query blocked by a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && (s1_op_q == OP_QUERY) && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked query");

  // A result beat appears only after a query left the input register.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(qy_go))
    else $error("result beat without a query");

  // A clearing query strobes the clear of exactly one pin.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qy_go && (q_clear != '0)) |=> ($past(q_clear) & ~{PIN_COUNT{1'b0}}) != '0 &&
      $onehot($past(q_clear)))
    else $error("clear strobe not one-hot");

  // An event never produces a result beat.
  a_event_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_go && !qy_go && out_free) |=> !out_valid_q)
    else $error("event produced a result beat");
`endif

endmodule
